// File: sv/irs_pkg.sv
package irs_pkg;

    typedef enum logic [1:0] {
        OP_EVENT = 2'd0,
        OP_WRITE = 2'd1,
        OP_READ  = 2'd2,
        OP_UNUSED = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ACT_NONE    = 3'd0,
        ACT_START   = 3'd1,
        ACT_TX      = 3'd2,
        ACT_RESTART = 3'd3,
        ACT_RECV    = 3'd4,
        ACT_NACK    = 3'd5,
        ACT_STOP    = 3'd6
    } action_t;

    localparam logic [6:0] DEV_ADDR_RESET = 7'd72;
    localparam logic       RW_WRITE       = 1'b0;
    localparam logic       RW_READ        = 1'b1;

    typedef struct packed {
        logic [2:0] action;
        logic [7:0] tx_byte;
        logic [7:0] read_data;
        logic       read_valid;
        logic       busy_res;
        logic       rejected;
    } result_t;

endpackage

// File: sv/i2c_register_access_sequencer.sv
// Each result is registered into the output stage at its accepting edge, in the skid entry if the main one is full.
// Throughput: one item per cycle while in_ready is high; the sequence state is updated at the accepting edge.
// A two-entry output stage absorbs one extra result while out_ready is low,
// so in_ready drops only when both entries are full.
// Reset (rst_n low, asynchronous): phase idle, no start pending, held bytes zero,
// output stage empty, device_address back to 72.
module i2c_register_access_sequencer (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [1:0] op,
    input  logic [7:0] register_number,
    input  logic [7:0] write_byte,
    input  logic       nack_seen,
    input  logic [7:0] received_byte,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [2:0] action,
    output logic [7:0] tx_byte,
    output logic [7:0] read_data,
    output logic       read_valid,
    output logic       busy_res,
    output logic       rejected,
    input  logic       cfg_we,
    input  logic [6:0] cfg_data
);
    import irs_pkg::*;

    logic    accept;
    logic    can_load;
    result_t step_result;
    result_t out_result;

    assign in_ready = can_load;
    assign accept   = in_valid && can_load;

    irs_seq u_seq (
        .clk             (clk),
        .rst_n           (rst_n),
        .accept          (accept),
        .op              (op),
        .register_number (register_number),
        .write_byte      (write_byte),
        .nack_seen       (nack_seen),
        .received_byte   (received_byte),
        .cfg_we          (cfg_we),
        .cfg_data        (cfg_data),
        .result          (step_result)
    );

    irs_out_skid u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (accept),
        .load_data (step_result),
        .can_load  (can_load),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_result)
    );

    assign action     = out_result.action;
    assign tx_byte    = out_result.tx_byte;
    assign read_data  = out_result.read_data;
    assign read_valid = out_result.read_valid;
    assign busy_res   = out_result.busy_res;
    assign rejected   = out_result.rejected;

endmodule

// File: sv/irs_seq.sv
module irs_seq (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               accept,
    input  logic [1:0]         op,
    input  logic [7:0]         register_number,
    input  logic [7:0]         write_byte,
    input  logic               nack_seen,
    input  logic [7:0]         received_byte,
    input  logic               cfg_we,
    input  logic [6:0]         cfg_data,
    output irs_pkg::result_t   result
);
    import irs_pkg::*;

    typedef enum logic [3:0] {
        PH_IDLE    = 4'd0,
        PH_ADDR    = 4'd1,
        PH_REG     = 4'd2,
        PH_DATA    = 4'd3,
        PH_RESTART = 4'd4,
        PH_ADDR_RD = 4'd5,
        PH_RECV    = 4'd6,
        PH_NACK    = 4'd7,
        PH_STOP    = 4'd8
    } phase_t;

    phase_t     phase_reg, phase_next;
    logic       is_read_reg, is_read_next;
    logic [7:0] held_register_reg, held_register_next;
    logic [7:0] held_write_byte_reg, held_write_byte_next;
    logic       started_reg, started_next;
    logic [6:0] dev_addr_reg;
    logic       busy;

    always_comb
    begin
        phase_next           = phase_reg;
        is_read_next         = is_read_reg;
        held_register_next   = held_register_reg;
        held_write_byte_next = held_write_byte_reg;
        started_next         = started_reg;
        result               = '0;
        result.action        = ACT_NONE;
        busy                 = (phase_reg != PH_IDLE) || started_reg;

        case (op_t'(op))
            OP_WRITE, OP_READ:
            begin
                if (busy)
                begin
                    result.rejected = 1'b1;
                end
                else
                begin
                    held_register_next = register_number;
                    if (op_t'(op) == OP_WRITE)
                    begin
                        held_write_byte_next = write_byte;
                    end
                    is_read_next  = (op_t'(op) == OP_READ);
                    started_next  = 1'b1;
                    result.action = ACT_START;
                end
            end
            OP_EVENT:
            begin
                case (phase_reg)
                    PH_IDLE:
                    begin
                        if (started_reg)
                        begin
                            started_next   = 1'b0;
                            result.action  = ACT_TX;
                            result.tx_byte = {dev_addr_reg, RW_WRITE};
                            phase_next     = PH_ADDR;
                        end
                    end
                    PH_ADDR:
                    begin
                        if (nack_seen)
                        begin
                            result.action = ACT_STOP;
                            phase_next    = PH_STOP;
                        end
                        else
                        begin
                            result.action  = ACT_TX;
                            result.tx_byte = held_register_reg;
                            phase_next     = PH_REG;
                        end
                    end
                    PH_REG:
                    begin
                        // register NACK ends the transfer as well
                        if (nack_seen)
                        begin
                            result.action = ACT_STOP;
                            phase_next    = PH_STOP;
                        end
                        else if (is_read_reg)
                        begin
                            result.action = ACT_RESTART;
                            phase_next    = PH_RESTART;
                        end
                        else
                        begin
                            result.action  = ACT_TX;
                            result.tx_byte = held_write_byte_reg;
                            phase_next     = PH_DATA;
                        end
                    end
                    PH_RESTART:
                    begin
                        result.action  = ACT_TX;
                        result.tx_byte = {dev_addr_reg, RW_READ};
                        phase_next     = PH_ADDR_RD;
                    end
                    PH_ADDR_RD:
                    begin
                        if (nack_seen)
                        begin
                            result.action = ACT_STOP;
                            phase_next    = PH_STOP;
                        end
                        else
                        begin
                            result.action = ACT_RECV;
                            phase_next    = PH_RECV;
                        end
                    end
                    PH_RECV:
                    begin
                        // single-byte read: always finish with NACK
                        result.read_data  = received_byte;
                        result.read_valid = 1'b1;
                        result.action     = ACT_NACK;
                        phase_next        = PH_NACK;
                    end
                    PH_DATA, PH_NACK:
                    begin
                        result.action = ACT_STOP;
                        phase_next    = PH_STOP;
                    end
                    default:
                    begin
                        phase_next = PH_IDLE;
                    end
                endcase
            end
            default:
            begin
            end
        endcase

        result.busy_res = (phase_next != PH_IDLE) || started_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg           <= PH_IDLE;
            is_read_reg         <= 1'b0;
            held_register_reg   <= '0;
            held_write_byte_reg <= '0;
            started_reg         <= 1'b0;
            dev_addr_reg        <= DEV_ADDR_RESET;
        end
        else
        begin
            if (accept)
            begin
                phase_reg           <= phase_next;
                is_read_reg         <= is_read_next;
                held_register_reg   <= held_register_next;
                held_write_byte_reg <= held_write_byte_next;
                started_reg         <= started_next;
            end
            if (cfg_we)
            begin
                dev_addr_reg <= cfg_data;
            end
        end
    end

endmodule

// File: sv/irs_out_skid.sv
module irs_out_skid (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             load,
    input  irs_pkg::result_t load_data,
    output logic             can_load,
    output logic             out_valid,
    input  logic             out_ready,
    output irs_pkg::result_t out_data
);
    import irs_pkg::*;

    logic    main_valid_reg;
    logic    skid_valid_reg;
    result_t main_reg;
    result_t skid_reg;
    logic    pop;

    assign pop       = main_valid_reg && out_ready;
    assign can_load  = !skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_data  = main_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
            main_reg       <= '0;
            skid_reg       <= '0;
        end
        else
        begin
            if (skid_valid_reg)
            begin
                // no load while the skid entry is held
                if (pop)
                begin
                    main_reg       <= skid_reg;
                    skid_valid_reg <= 1'b0;
                end
            end
            else if (load)
            begin
                if (!main_valid_reg || pop)
                begin
                    main_reg       <= load_data;
                    main_valid_reg <= 1'b1;
                end
                else
                begin
                    skid_reg       <= load_data;
                    skid_valid_reg <= 1'b1;
                end
            end
            else if (pop)
            begin
                main_valid_reg <= 1'b0;
            end
        end
    end

endmodule

// File: sv/irs_checker.sv
module irs_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_ready,
    input logic [2:0] action,
    input logic [7:0] tx_byte,
    input logic       read_valid,
    input logic       busy_res,
    input logic       rejected
);
    import irs_pkg::*;

    // hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(action) && $stable(tx_byte))
        else $error("result changed while stalled");

    // received byte only comes with the NACK action
    a_read_nack: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && read_valid |-> action == ACT_NACK)
        else $error("read_valid without NACK action");

    a_reject_none: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && rejected |-> action == ACT_NONE && busy_res)
        else $error("rejected begin produced an action");

    a_tx_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && action != ACT_TX |-> tx_byte == 8'd0)
        else $error("tx_byte set without transmit");

    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (action == ACT_START || action == ACT_TX ||
                      action == ACT_RESTART || action == ACT_RECV ||
                      action == ACT_NACK || action == ACT_STOP) |-> busy_res)
        else $error("active bus action reported as idle");

endmodule

bind i2c_register_access_sequencer irs_checker u_irs_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .action     (action),
    .tx_byte    (tx_byte),
    .read_valid (read_valid),
    .busy_res   (busy_res),
    .rejected   (rejected)
);

// File: test/i2c_register_access_sequencer_tb.sv
`timescale 1ns / 100ps

module i2c_register_access_sequencer_tb;
    import irs_pkg::*;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int RANDOM_ITEMS  = 1600;
    localparam int ADDR_SETTINGS = 6;

    typedef enum logic [3:0] {
        PH_IDLE    = 4'd0,
        PH_ADDR    = 4'd1,
        PH_REG     = 4'd2,
        PH_DATA    = 4'd3,
        PH_RESTART = 4'd4,
        PH_ADDR_RD = 4'd5,
        PH_RECV    = 4'd6,
        PH_NACK    = 4'd7,
        PH_STOP    = 4'd8
    } seq_phase_t;

    // Tracks the bus sequence and holds the per-transfer results still owed.
    class bus_step_predictor;
        seq_phase_t phase;
        bit         is_read;
        bit         started;
        bit [7:0]   held_reg;
        bit [7:0]   held_wb;
        bit [6:0]   dev_addr;
        result_t    owed_steps[$];
        int         failures;
        int         steps_seen;
        int         reads_seen;
        int         rejects_seen;

        function new();
            phase        = PH_IDLE;
            is_read      = 1'b0;
            started      = 1'b0;
            held_reg     = '0;
            held_wb      = '0;
            dev_addr     = DEV_ADDR_RESET;
            failures     = 0;
            steps_seen   = 0;
            reads_seen   = 0;
            rejects_seen = 0;
        endfunction

        function void set_address(bit [6:0] a);
            dev_addr = a;
        endfunction

        function bit is_quiet();
            return (phase == PH_IDLE) && !started;
        endfunction

        function int pending();
            return owed_steps.size();
        endfunction

        function void note_item(logic [1:0] op_v, logic [7:0] reg_v, logic [7:0] wb_v,
                                logic nack, logic [7:0] rx_v);
            result_t r;
            r = '0;
            if (op_v == OP_WRITE || op_v == OP_READ) begin
                if (!is_quiet()) begin
                    r.rejected = 1'b1;
                end
                else begin
                    held_reg = reg_v;
                    if (op_v == OP_WRITE)
                        held_wb = wb_v;
                    is_read  = (op_v == OP_READ);
                    started  = 1'b1;
                    r.action = ACT_START;
                end
            end
            else if (op_v == OP_EVENT) begin
                case (phase)
                    PH_IDLE: begin
                        if (started) begin
                            started   = 1'b0;
                            r.action  = ACT_TX;
                            r.tx_byte = {dev_addr, RW_WRITE};
                            phase     = PH_ADDR;
                        end
                    end
                    PH_ADDR: begin
                        if (nack) begin
                            r.action = ACT_STOP;
                            phase    = PH_STOP;
                        end
                        else begin
                            r.action  = ACT_TX;
                            r.tx_byte = held_reg;
                            phase     = PH_REG;
                        end
                    end
                    PH_REG: begin
                        if (nack) begin
                            r.action = ACT_STOP;
                            phase    = PH_STOP;
                        end
                        else if (is_read) begin
                            r.action = ACT_RESTART;
                            phase    = PH_RESTART;
                        end
                        else begin
                            r.action  = ACT_TX;
                            r.tx_byte = held_wb;
                            phase     = PH_DATA;
                        end
                    end
                    PH_RESTART: begin
                        r.action  = ACT_TX;
                        r.tx_byte = {dev_addr, RW_READ};
                        phase     = PH_ADDR_RD;
                    end
                    PH_ADDR_RD: begin
                        if (nack) begin
                            r.action = ACT_STOP;
                            phase    = PH_STOP;
                        end
                        else begin
                            r.action = ACT_RECV;
                            phase    = PH_RECV;
                        end
                    end
                    PH_RECV: begin
                        r.read_data  = rx_v;
                        r.read_valid = 1'b1;
                        r.action     = ACT_NACK;
                        phase        = PH_NACK;
                    end
                    PH_DATA, PH_NACK: begin
                        r.action = ACT_STOP;
                        phase    = PH_STOP;
                    end
                    default: phase = PH_IDLE;
                endcase
            end
            r.busy_res = !is_quiet();
            owed_steps.push_back(r);
        endfunction

        function void cmp_field(string name, logic [7:0] e, logic [7:0] g);
            if (e !== g) begin
                $error("%s mismatch: expected %0d, actual %0d", name, e, g);
                failures++;
            end
        endfunction

        function void check_step(result_t got);
            result_t e;
            steps_seen++;
            if (owed_steps.size() == 0) begin
                $error("result with nothing owed: action %0d tx_byte %0d", got.action,
                       got.tx_byte);
                failures++;
                return;
            end
            e = owed_steps.pop_front();
            if (e.read_valid)
                reads_seen++;
            if (e.rejected)
                rejects_seen++;
            cmp_field("action", 8'(e.action), 8'(got.action));
            cmp_field("tx_byte", e.tx_byte, got.tx_byte);
            cmp_field("read_data", e.read_data, got.read_data);
            cmp_field("read_valid", 8'(e.read_valid), 8'(got.read_valid));
            cmp_field("busy_res", 8'(e.busy_res), 8'(got.busy_res));
            cmp_field("rejected", 8'(e.rejected), 8'(got.rejected));
        endfunction
    endclass

    logic       clk = 1'b0;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    logic [1:0] op;
    logic [7:0] register_number;
    logic [7:0] write_byte;
    logic       nack_seen;
    logic [7:0] received_byte;
    logic       out_valid;
    logic       out_ready;
    logic [2:0] action;
    logic [7:0] tx_byte;
    logic [7:0] read_data;
    logic       read_valid;
    logic       busy_res;
    logic       rejected;
    logic       cfg_we;
    logic [6:0] cfg_data;

    bus_step_predictor sb = new();
    int items_sent  = 0;
    int addr_writes = 0;
    int cycles      = 0;
    int in_calm     = 0;
    int out_calm    = 0;

    i2c_register_access_sequencer dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .op              (op),
        .register_number (register_number),
        .write_byte      (write_byte),
        .nack_seen       (nack_seen),
        .received_byte   (received_byte),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .action          (action),
        .tx_byte         (tx_byte),
        .read_data       (read_data),
        .read_valid      (read_valid),
        .busy_res        (busy_res),
        .rejected        (rejected),
        .cfg_we          (cfg_we),
        .cfg_data        (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results owed", cycles, sb.pending());
            $display("status: fail");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_step(result_t'({action, tx_byte, read_data, read_valid, busy_res,
                                     rejected}));
    end

    // Wait count per item; now and then a run of items with no wait at all.
    function automatic int draw_gap(ref int calm);
        if (calm > 0) begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0) begin
            calm = $urandom_range(8, 40);
            return 0;
        end
        return $urandom_range(0, 12);
    endfunction

    initial
    begin
        int n;
        out_ready <= 1'b0;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever begin
            n = draw_gap(out_calm);
            if (n > 0) begin
                out_ready <= 1'b0;
                repeat (n) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
        end
    end

    task automatic send_item(input logic [1:0] op_v, input logic [7:0] reg_v,
                             input logic [7:0] wb_v, input logic nk,
                             input logic [7:0] rx_v);
        int gap;
        gap = draw_gap(in_calm);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid        <= 1'b1;
        op              <= op_v;
        register_number <= reg_v;
        write_byte      <= wb_v;
        nack_seen       <= nk;
        received_byte   <= rx_v;
        do @(posedge clk); while (!in_ready);
        sb.note_item(op_v, reg_v, wb_v, nk, rx_v);
        items_sent++;
    endtask

    // Pump byte-phase events until the sequence is back at idle. NACK goes on
    // event number nack_at, or at random with odds 1 in nack_odds.
    task automatic finish_access(input int nack_at, input int nack_odds, input bit strays,
                                 input logic [7:0] rx_v);
        int  k;
        bit  nk;
        k = 0;
        while (!sb.is_quiet() && k < 12) begin
            if (strays && $urandom_range(0, 15) == 0)
                send_item(2'($urandom_range(1, 3)), 8'($urandom_range(0, 255)),
                          8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                          8'($urandom_range(0, 255)));
            k++;
            nk = (k == nack_at) || (nack_odds > 0 && $urandom_range(1, nack_odds) == 1);
            send_item(OP_EVENT, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                      nk, rx_v);
        end
    endtask

    task automatic run_access(input bit rd, input logic [7:0] reg_v, input logic [7:0] wb_v,
                              input int nack_at, input int nack_odds, input bit strays,
                              input logic [7:0] rx_v);
        send_item(rd ? OP_READ : OP_WRITE, reg_v, wb_v, 1'($urandom_range(0, 1)),
                  8'($urandom_range(0, 255)));
        finish_access(nack_at, nack_odds, strays, rx_v);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic write_address(input logic [6:0] a);
        cfg_we   <= 1'b1;
        cfg_data <= a;
        @(posedge clk);
        sb.set_address(a);
        addr_writes++;
        cfg_we <= 1'b0;
    endtask

    initial
    begin
        int target;
        rst_n           <= 1'b0;
        in_valid        <= 1'b0;
        op              <= OP_EVENT;
        register_number <= '0;
        write_byte      <= '0;
        nack_seen       <= 1'b0;
        received_byte   <= '0;
        cfg_we          <= 1'b0;
        cfg_data        <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part at the reset address.
        send_item(OP_EVENT, 8'hFF, 8'hFF, 1'b1, 8'hFF);
        send_item(OP_UNUSED, 8'hFF, 8'hFF, 1'b1, 8'hFF);
        send_item(OP_WRITE, 8'hFF, 8'h00, 1'b0, 8'h00);
        send_item(OP_READ, 8'h00, 8'hFF, 1'b0, 8'h00);
        finish_access(4, 0, 1'b0, 8'h00);
        run_access(1'b1, 8'h00, 8'hFF, 0, 0, 1'b0, 8'hFF);
        run_access(1'b0, 8'h5A, 8'hA5, 2, 0, 1'b0, 8'h00);
        run_access(1'b1, 8'hFF, 8'h00, 3, 0, 1'b0, 8'h00);
        drain();

        // Random part, one device address per stretch.
        for (int p = 0; p < ADDR_SETTINGS; p++) begin
            case (p)
                0:       write_address(7'h00);
                1:       write_address(7'h7F);
                default: write_address(7'($urandom_range(1, 126)));
            endcase
            target = items_sent + RANDOM_ITEMS / ADDR_SETTINGS;
            while (items_sent < target) begin
                if ($urandom_range(0, 4) == 0)
                    send_item(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                              8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                              8'($urandom_range(0, 255)));
                else
                    run_access(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                               8'($urandom_range(0, 255)), 0, 10, 1'b1,
                               8'($urandom_range(0, 255)));
            end
            drain();
        end

        $display("ran %0d transfers in, %0d results checked, %0d register reads returned",
                 items_sent, sb.steps_seen, sb.reads_seen);
        $display("%0d begins rejected while busy, %0d device address settings",
                 sb.rejects_seen, addr_writes + 1);
        if (sb.failures == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
